>>> rtl/wmpm_pkg.sv
`default_nettype none

package wmpm_pkg;

   localparam int DEF_MAX_NODES   = 4096;
   localparam int DEF_ALPHABET    = 26;
   localparam int DEF_SCORE_WIDTH = 48;

   localparam int OP_WIDTH     = 3;
   localparam int SYMBOL_WIDTH = 5;
   localparam int WEIGHT_WIDTH = 20;
   localparam int STATUS_WIDTH = 2;

   localparam logic [OP_WIDTH-1:0] OP_CLEAR   = 3'd0;
   localparam logic [OP_WIDTH-1:0] OP_PATTERN = 3'd1;
   localparam logic [OP_WIDTH-1:0] OP_END     = 3'd2;
   localparam logic [OP_WIDTH-1:0] OP_BUILD   = 3'd3;
   localparam logic [OP_WIDTH-1:0] OP_TEXT    = 3'd4;

   localparam logic [STATUS_WIDTH-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_FULL = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_SAT  = 2'd2;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_PAT_RD,
      ST_PAT_CHILD,
      ST_PAT_LINK,
      ST_END_RD,
      ST_TXT_TR,
      ST_TXT_W,
      ST_B_ROOT,
      ST_B_ROOT_C,
      ST_B_ROOT_W,
      ST_B_DEQ,
      ST_B_U,
      ST_B_F,
      ST_B_A,
      ST_B_AD,
      ST_B_VW,
      ST_B_CW
   } state_type;

endpackage

`default_nettype wire

>>> rtl/wmpm_ram.sv
`default_nettype none

module wmpm_ram import wmpm_pkg::*; #(
   parameter int DEPTH = DEF_MAX_NODES,
   parameter int WIDTH = 12
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/wmpm_engine.sv
`default_nettype none

module wmpm_engine import wmpm_pkg::*; #(
   parameter int MAX_NODES   = DEF_MAX_NODES,
   parameter int ALPHABET    = DEF_ALPHABET,
   parameter int SCORE_WIDTH = DEF_SCORE_WIDTH
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [OP_WIDTH-1:0]           req_operation,
   input  wire logic [SYMBOL_WIDTH-1:0]       req_symbol,
   input  wire logic [WEIGHT_WIDTH-1:0]       req_weight,
   input  wire logic                          req_restart_text,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [SCORE_WIDTH-1:0]             rsp_score,
   output logic [$clog2(MAX_NODES)-1:0]       rsp_node,
   output logic [STATUS_WIDTH-1:0]            rsp_status
);

   localparam int NW = $clog2(MAX_NODES);
   localparam int AB = $clog2(ALPHABET);
   localparam int TD = MAX_NODES * ALPHABET;
   localparam int AW = $clog2(TD);
   localparam int SW = SCORE_WIDTH;

   function automatic logic [AW-1:0] taddr(input logic [NW-1:0] n, input logic [AB-1:0] a);
      return AW'(n) * AW'(ALPHABET) + AW'(a);
   endfunction

   function automatic logic [SW:0] sat_add(input logic [SW-1:0] x, input logic [SW-1:0] y);
      logic [SW:0] s;
      s = {1'b0, x} + {1'b0, y};
      // top bit flags saturation
      if (s[SW]) s = {1'b1, {SW{1'b1}}};
      return s;
   endfunction

   // memories
   logic          ch_we, tr_we, pr_we, fl_we, wt_we, qu_we;
   logic [AW-1:0] ch_wa, ch_ra, tr_wa, tr_ra;
   logic [NW-1:0] ch_wd, ch_rd, tr_wd, tr_rd;
   logic [NW-1:0] pr_wa, pr_ra, fl_wa, fl_ra, wt_wa, wt_ra, qu_wa, qu_ra;
   logic [ALPHABET-1:0] pr_wd, pr_rd;
   logic [NW-1:0] fl_wd, fl_rd, qu_wd, qu_rd;
   logic [SW-1:0] wt_wd, wt_rd;

   wmpm_ram #(.DEPTH(TD), .WIDTH(NW)) u_child (
      .clock, .wr_en(ch_we), .wr_addr(ch_wa), .wr_data(ch_wd), .rd_addr(ch_ra), .rd_data(ch_rd));
   wmpm_ram #(.DEPTH(TD), .WIDTH(NW)) u_trans (
      .clock, .wr_en(tr_we), .wr_addr(tr_wa), .wr_data(tr_wd), .rd_addr(tr_ra), .rd_data(tr_rd));
   wmpm_ram #(.DEPTH(MAX_NODES), .WIDTH(ALPHABET)) u_present (
      .clock, .wr_en(pr_we), .wr_addr(pr_wa), .wr_data(pr_wd), .rd_addr(pr_ra), .rd_data(pr_rd));
   wmpm_ram #(.DEPTH(MAX_NODES), .WIDTH(NW)) u_fail (
      .clock, .wr_en(fl_we), .wr_addr(fl_wa), .wr_data(fl_wd), .rd_addr(fl_ra), .rd_data(fl_rd));
   wmpm_ram #(.DEPTH(MAX_NODES), .WIDTH(SW)) u_weight (
      .clock, .wr_en(wt_we), .wr_addr(wt_wa), .wr_data(wt_wd), .rd_addr(wt_ra), .rd_data(wt_rd));
   wmpm_ram #(.DEPTH(MAX_NODES), .WIDTH(NW)) u_queue (
      .clock, .wr_en(qu_we), .wr_addr(qu_wa), .wr_data(qu_wd), .rd_addr(qu_ra), .rd_data(qu_rd));

   state_type state_ff, state_in;
   logic [NW:0]         count_ff, count_in;
   logic [NW-1:0]       cursor_ff, cursor_in, scan_ff, scan_in;
   logic [SW-1:0]       score_ff, score_in, root_w_ff, root_w_in;
   logic [ALPHABET-1:0] root_pr_ff, root_pr_in;
   logic                sat_ff, sat_in;
   logic [NW-1:0]       head_ff, head_in, tail_ff, tail_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // payload registers, no reset
   logic [AB-1:0]       sym_ff, sym_in, a_ff, a_in;
   logic [NW-1:0]       u_ff, u_in, f_ff, f_in, via_ff, via_in, c_ff, c_in;
   logic [ALPHABET-1:0] row_ff, row_in;
   logic [SW-1:0]       vw_ff, vw_in, rsp_score_ff, rsp_score_in;
   logic [NW-1:0]       rsp_node_ff, rsp_node_in;
   logic [STATUS_WIDTH-1:0] rsp_status_ff, rsp_status_in;

   logic          accept;
   logic          sym_ok;
   logic [AB-1:0] req_sym_idx;
   logic [SW-1:0] w_ext;
   logic          w_big;
   logic [SW:0]   sum;
   logic [NW-1:0] n_new;
   logic [NW-1:0] scan_eff;
   logic [SW-1:0] score_eff;
   logic          a_last;

   assign req_stall   = (state_ff != ST_IDLE) || rsp_valid_ff;
   assign accept      = req_valid && !req_stall;
   assign sym_ok      = 32'(req_symbol) < ALPHABET;
   assign req_sym_idx = AB'(req_symbol);
   assign w_big       = (SW < WEIGHT_WIDTH) && ((32'(req_weight) >> SW) != 32'd0);
   assign w_ext       = w_big ? {SW{1'b1}} : SW'(req_weight);
   assign n_new       = count_ff[NW-1:0];
   assign scan_eff    = req_restart_text ? '0 : scan_ff;
   assign score_eff   = req_restart_text ? '0 : score_ff;
   assign a_last      = a_ff == AB'(ALPHABET - 1);

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_score  = rsp_score_ff;
   assign rsp_node   = rsp_node_ff;
   assign rsp_status = rsp_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= (NW+1)'(1);
         cursor_ff    <= '0;
         scan_ff      <= '0;
         score_ff     <= '0;
         root_w_ff    <= '0;
         root_pr_ff   <= '0;
         sat_ff       <= 1'b0;
         head_ff      <= '0;
         tail_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cursor_ff    <= cursor_in;
         scan_ff      <= scan_in;
         score_ff     <= score_in;
         root_w_ff    <= root_w_in;
         root_pr_ff   <= root_pr_in;
         sat_ff       <= sat_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sym_ff        <= sym_in;
      a_ff          <= a_in;
      u_ff          <= u_in;
      f_ff          <= f_in;
      via_ff        <= via_in;
      c_ff          <= c_in;
      row_ff        <= row_in;
      vw_ff         <= vw_in;
      rsp_score_ff  <= rsp_score_in;
      rsp_node_ff   <= rsp_node_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      cursor_in     = cursor_ff;
      scan_in       = scan_ff;
      score_in      = score_ff;
      root_w_in     = root_w_ff;
      root_pr_in    = root_pr_ff;
      sat_in        = sat_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      sym_in        = sym_ff;
      a_in          = a_ff;
      u_in          = u_ff;
      f_in          = f_ff;
      via_in        = via_ff;
      c_in          = c_ff;
      row_in        = row_ff;
      vw_in         = vw_ff;
      rsp_score_in  = rsp_score_ff;
      rsp_node_in   = rsp_node_ff;
      rsp_status_in = rsp_status_ff;
      sum           = '0;

      ch_we = 1'b0; ch_wa = '0; ch_wd = '0; ch_ra = '0;
      tr_we = 1'b0; tr_wa = '0; tr_wd = '0; tr_ra = '0;
      pr_we = 1'b0; pr_wa = '0; pr_wd = '0; pr_ra = '0;
      fl_we = 1'b0; fl_wa = '0; fl_wd = '0; fl_ra = '0;
      wt_we = 1'b0; wt_wa = '0; wt_wd = '0; wt_ra = '0;
      qu_we = 1'b0; qu_wa = '0; qu_wd = '0; qu_ra = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               sym_in        = req_sym_idx;
               rsp_status_in = STATUS_OK;
               rsp_score_in  = score_ff;
               case (req_operation)
                  OP_CLEAR: begin
                     count_in     = (NW+1)'(1);
                     root_pr_in   = '0;
                     root_w_in    = '0;
                     cursor_in    = '0;
                     scan_in      = '0;
                     score_in     = '0;
                     rsp_score_in = '0;
                     rsp_node_in  = '0;
                     rsp_valid_in = 1'b1;
                  end
                  OP_PATTERN: begin
                     if (sym_ok) begin
                        pr_ra    = cursor_ff;
                        state_in = ST_PAT_RD;
                     end else begin
                        rsp_node_in  = cursor_ff;
                        rsp_valid_in = 1'b1;
                     end
                  end
                  OP_END: begin
                     rsp_node_in = cursor_ff;
                     cursor_in   = '0;
                     if (cursor_ff == '0) begin
                        sum           = sat_add(root_w_ff, w_ext);
                        root_w_in     = sum[SW-1:0];
                        rsp_status_in = (sum[SW] || w_big) ? STATUS_SAT : STATUS_OK;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        // weight is held here since the request may move on
                        vw_in    = w_ext;
                        sat_in   = w_big;
                        wt_ra    = cursor_ff;
                        state_in = ST_END_RD;
                     end
                  end
                  OP_BUILD: begin
                     scan_in  = '0;
                     score_in = '0;
                     sat_in   = 1'b0;
                     a_in     = '0;
                     head_in  = '0;
                     tail_in  = '0;
                     state_in = ST_B_ROOT;
                  end
                  OP_TEXT: begin
                     scan_in  = scan_eff;
                     score_in = score_eff;
                     if (sym_ok) begin
                        tr_ra    = taddr(scan_eff, req_sym_idx);
                        state_in = ST_TXT_TR;
                     end else begin
                        rsp_score_in = score_eff;
                        rsp_node_in  = scan_eff;
                        rsp_valid_in = 1'b1;
                     end
                  end
                  default: begin
                     rsp_node_in  = scan_ff;
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end

         ST_PAT_RD: begin
            row_in = (cursor_ff == '0) ? root_pr_ff : pr_rd;
            if (row_in[sym_ff]) begin
               ch_ra    = taddr(cursor_ff, sym_ff);
               state_in = ST_PAT_CHILD;
            end else if (count_ff < (NW+1)'(MAX_NODES)) begin
               ch_we = 1'b1; ch_wa = taddr(cursor_ff, sym_ff); ch_wd = n_new;
               wt_we = 1'b1; wt_wa = n_new; wt_wd = '0;
               pr_we = 1'b1; pr_wa = n_new; pr_wd = '0;
               state_in = ST_PAT_LINK;
            end else begin
               rsp_node_in   = cursor_ff;
               rsp_status_in = STATUS_FULL;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end

         ST_PAT_CHILD: begin
            cursor_in    = ch_rd;
            rsp_node_in  = ch_rd;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end

         ST_PAT_LINK: begin
            // new node's row was written last cycle; now mark it in the parent row
            if (cursor_ff == '0) begin
               root_pr_in[sym_ff] = 1'b1;
            end else begin
               pr_we = 1'b1;
               pr_wa = cursor_ff;
               pr_wd = row_ff;
               pr_wd[sym_ff] = 1'b1;
            end
            cursor_in    = n_new;
            count_in     = count_ff + (NW+1)'(1);
            rsp_node_in  = n_new;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end

         ST_END_RD: begin
            sum   = sat_add(wt_rd, vw_ff);
            wt_we = 1'b1; wt_wa = rsp_node_ff; wt_wd = sum[SW-1:0];
            rsp_status_in = (sum[SW] || sat_ff) ? STATUS_SAT : STATUS_OK;
            rsp_valid_in  = 1'b1;
            state_in      = ST_IDLE;
         end

         ST_TXT_TR: begin
            scan_in = tr_rd;
            if (tr_rd == '0) begin
               sum           = sat_add(score_ff, root_w_ff);
               score_in      = sum[SW-1:0];
               rsp_score_in  = sum[SW-1:0];
               rsp_node_in   = tr_rd;
               rsp_status_in = sum[SW] ? STATUS_SAT : STATUS_OK;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               wt_ra    = tr_rd;
               state_in = ST_TXT_W;
            end
         end

         ST_TXT_W: begin
            sum           = sat_add(score_ff, wt_rd);
            score_in      = sum[SW-1:0];
            rsp_score_in  = sum[SW-1:0];
            rsp_node_in   = scan_ff;
            rsp_status_in = sum[SW] ? STATUS_SAT : STATUS_OK;
            rsp_valid_in  = 1'b1;
            state_in      = ST_IDLE;
         end

         // root level of the breadth-first pass
         ST_B_ROOT: begin
            if (root_pr_ff[a_ff]) begin
               ch_ra    = taddr('0, a_ff);
               state_in = ST_B_ROOT_C;
            end else begin
               tr_we = 1'b1; tr_wa = taddr('0, a_ff); tr_wd = '0;
               a_in     = a_ff + AB'(1);
               state_in = a_last ? ST_B_DEQ : ST_B_ROOT;
            end
         end

         ST_B_ROOT_C: begin
            c_in  = ch_rd;
            wt_ra = ch_rd;
            tr_we = 1'b1; tr_wa = taddr('0, a_ff); tr_wd = ch_rd;
            qu_we = 1'b1; qu_wa = tail_ff;          qu_wd = ch_rd;
            fl_we = 1'b1; fl_wa = ch_rd;            fl_wd = '0;
            tail_in  = tail_ff + NW'(1);
            state_in = ST_B_ROOT_W;
         end

         ST_B_ROOT_W: begin
            sum    = sat_add(wt_rd, root_w_ff);
            wt_we  = 1'b1; wt_wa = c_ff; wt_wd = sum[SW-1:0];
            sat_in = sat_ff || sum[SW];
            a_in   = a_ff + AB'(1);
            state_in = a_last ? ST_B_DEQ : ST_B_ROOT;
         end

         ST_B_DEQ: begin
            if (head_ff == tail_ff) begin
               rsp_score_in  = '0;
               rsp_node_in   = '0;
               rsp_status_in = sat_ff ? STATUS_SAT : STATUS_OK;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               qu_ra    = head_ff;
               head_in  = head_ff + NW'(1);
               state_in = ST_B_U;
            end
         end

         ST_B_U: begin
            u_in     = qu_rd;
            fl_ra    = qu_rd;
            pr_ra    = qu_rd;
            a_in     = '0;
            state_in = ST_B_F;
         end

         ST_B_F: begin
            f_in     = fl_rd;
            row_in   = pr_rd;
            state_in = ST_B_A;
         end

         ST_B_A: begin
            tr_ra    = taddr(f_ff, a_ff);
            ch_ra    = taddr(u_ff, a_ff);
            state_in = ST_B_AD;
         end

         ST_B_AD: begin
            via_in = tr_rd;
            if (row_ff[a_ff]) begin
               c_in  = ch_rd;
               fl_we = 1'b1; fl_wa = ch_rd;            fl_wd = tr_rd;
               tr_we = 1'b1; tr_wa = taddr(u_ff, a_ff); tr_wd = ch_rd;
               qu_we = 1'b1; qu_wa = tail_ff;          qu_wd = ch_rd;
               tail_in  = tail_ff + NW'(1);
               wt_ra    = tr_rd;
               state_in = ST_B_VW;
            end else begin
               tr_we = 1'b1; tr_wa = taddr(u_ff, a_ff); tr_wd = tr_rd;
               a_in     = a_ff + AB'(1);
               state_in = a_last ? ST_B_DEQ : ST_B_A;
            end
         end

         ST_B_VW: begin
            vw_in    = (via_ff == '0) ? root_w_ff : wt_rd;
            wt_ra    = c_ff;
            state_in = ST_B_CW;
         end

         ST_B_CW: begin
            sum    = sat_add(wt_rd, vw_ff);
            wt_we  = 1'b1; wt_wa = c_ff; wt_wd = sum[SW-1:0];
            sat_in = sat_ff || sum[SW];
            a_in   = a_ff + AB'(1);
            state_in = a_last ? ST_B_DEQ : ST_B_A;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> rtl/weighted_multi_pattern_matcher.sv
`default_nettype none

// channel  | handshake            | payload
// req      | req_valid/req_stall  | operation, symbol, weight, restart_text
// rsp      | rsp_valid/rsp_stall  | score, node, status
//
// One item at a time; one result per item, held in an output register.
// Clear and unused codes answer from the idle state, as do letters past
// the alphabet and an end pattern at the root; other pattern, end and
// text items read memories first, a text letter its transition and weight.
// Build visits each root letter, then each letter of every queued node.
// Synchronous reset; no clearing pass, the root row and weight sit in flops.
// A stalled result holds the block until it is taken.

module weighted_multi_pattern_matcher import wmpm_pkg::*; #(
   parameter int MAX_NODES   = DEF_MAX_NODES,
   parameter int ALPHABET    = DEF_ALPHABET,
   parameter int SCORE_WIDTH = DEF_SCORE_WIDTH
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [OP_WIDTH-1:0]         req_operation,
   input  wire logic [SYMBOL_WIDTH-1:0]     req_symbol,
   input  wire logic [WEIGHT_WIDTH-1:0]     req_weight,
   input  wire logic                        req_restart_text,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [SCORE_WIDTH-1:0]           rsp_score,
   output logic [$clog2(MAX_NODES)-1:0]     rsp_node,
   output logic [STATUS_WIDTH-1:0]          rsp_status
);

   wmpm_engine #(
      .MAX_NODES  (MAX_NODES),
      .ALPHABET   (ALPHABET),
      .SCORE_WIDTH(SCORE_WIDTH)
   ) u_engine (
      .clock,
      .reset,
      .req_valid,
      .req_stall,
      .req_operation,
      .req_symbol,
      .req_weight,
      .req_restart_text,
      .rsp_valid,
      .rsp_stall,
      .rsp_score,
      .rsp_node,
      .rsp_status
   );

endmodule

`default_nettype wire
